[sv/hvns_pkg.sv]
// Shared constants for the hashed value-noise smoother.
`default_nettype none
package hvns_pkg;
  localparam int unsigned MAX_RANGE_DEF = 8;
  localparam int unsigned MAX_DEPTH_DEF = 4;

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned SEED_W   = 64;
  localparam int unsigned STRIDE_W = 13;
  localparam int unsigned RANGE_W  = 4;
  localparam int unsigned DEPTH_W  = 3;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned CFG_DW   = 64;
  localparam int unsigned CFG_AW   = 5;

  localparam logic [63:0] HASH_K = 64'hB5AD4ECEDA1CE2A9;

  localparam logic [1:0] REG_SEED   = 2'd0;
  localparam logic [1:0] REG_STRIDE = 2'd1;
  localparam logic [1:0] REG_RANGE  = 2'd2;
  localparam logic [1:0] REG_DEPTH  = 2'd3;

  localparam logic [SEED_W-1:0]   SEED_RST   = '0;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 13'd100;
  localparam logic [RANGE_W-1:0]  RANGE_RST  = 4'd2;
  localparam logic [DEPTH_W-1:0]  DEPTH_RST  = 3'd2;
endpackage
`default_nettype wire

[sv/hvns_ram.sv]
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module hvns_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[sv/hashed_value_noise_smoother.sv]
// Hashed value-noise smoother: sequencer around one shared 32x32 multiplier.
// Level 0 hashes a (2h+1)^2 grid; each later level l filters a (2e+1)^2 grid
//   with (2r+1)^2 taps per point, h = r*d, e = r*(d-l).
// Throughput: one item at a time; busy stays high from accept to the result strobe.
// The result strobe lasts one cycle and a new start is taken in that same cycle.
// Reset (rst_ni low, asynchronous) returns to idle and loads register defaults.
`default_nettype none
module hashed_value_noise_smoother #(
  parameter int unsigned MAX_RANGE = hvns_pkg::MAX_RANGE_DEF,
  parameter int unsigned MAX_DEPTH = hvns_pkg::MAX_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [hvns_pkg::COORD_W-1:0]  x_coord_i,
  input  wire logic [hvns_pkg::COORD_W-1:0]  y_coord_i,
  output logic                               noise_valid_o,
  output logic      [hvns_pkg::VALUE_W-1:0]  noise_value_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hvns_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [hvns_pkg::CFG_DW-1:0]   pwdata,
  output logic      [hvns_pkg::CFG_DW-1:0]   prdata,
  output logic                               pready
);
  localparam int unsigned CW     = hvns_pkg::COORD_W;
  localparam int unsigned VW     = hvns_pkg::VALUE_W;
  localparam int unsigned RW     = $clog2(MAX_RANGE + 1);
  localparam int unsigned DW     = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CTR    = MAX_RANGE * MAX_DEPTH;
  localparam int unsigned HW     = $clog2(CTR + 1);
  localparam int unsigned GW     = $clog2(2 * CTR + 1);
  localparam int unsigned RAM_AW = 2 * GW + 1;
  localparam int unsigned RAM_D  = 2 ** RAM_AW;
  localparam int unsigned WW     = $clog2(2 * MAX_RANGE);
  localparam int unsigned SW     = RW + 3;
  localparam int unsigned WSW    =
    $clog2((2 * MAX_RANGE + 1) * (2 * MAX_RANGE + 1) * (2 * MAX_RANGE - 1) + 1);
  localparam int unsigned VSW    = WSW + VW;
  localparam logic [GW-1:0] CTR_G = GW'(CTR);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_HMUL   = 4'd1;
  localparam logic [3:0] S_HSET   = 4'd2;
  localparam logic [3:0] S_RMUL   = 4'd3;
  localparam logic [3:0] S_RSET   = 4'd4;
  localparam logic [3:0] S_HASH   = 4'd5;
  localparam logic [3:0] S_TAP    = 4'd6;
  localparam logic [3:0] S_DRAIN  = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_DWR    = 4'd9;
  localparam logic [3:0] S_FINRD  = 4'd10;
  localparam logic [3:0] S_FINOUT = 4'd11;

  logic [hvns_pkg::SEED_W-1:0]   seed_q;
  logic [hvns_pkg::STRIDE_W-1:0] stride_q;
  logic [hvns_pkg::RANGE_W-1:0]  range_q;
  logic [hvns_pkg::DEPTH_W-1:0]  depth_q;

  logic [3:0]          state_q, state_d;
  logic [CW-1:0]       x_q, x_d, y_q, y_d;
  logic [RW-1:0]       r_q, r_d;
  logic [DW-1:0]       d_q, d_d, lvl_q, lvl_d;
  logic [HW-1:0]       h_q, h_d, e_q, e_d;
  logic [GW-1:0]       cx_q, cx_d, cy_q, cy_d;
  logic signed [RW:0]  dx_q, dx_d, dy_q, dy_d;
  logic [3:0]          hs_q, hs_d;
  logic [63:0]         lin_q, lin_d, lin_row_q, lin_row_d, n_q, n_d;
  logic [63:0]         acc_q, acc_d, m_q, m_d, prod_q, prod_d;
  logic                val1_q, val1_d, val2_q;
  logic [WW-1:0]       w1_q, w1_d, w2_q;
  logic [VSW-1:0]      vsum_q, vsum_d;
  logic [WSW-1:0]      wsum_q, wsum_d;
  logic [2:0]          ds_q, ds_d;
  logic [VW-1:0]       q_q, q_d, out_q, out_d;
  logic                oval_q, oval_d;

  logic [31:0]         ma, mb;
  logic                ram_we;
  logic [RAM_AW-1:0]   ram_waddr, ram_raddr;
  logic [VW-1:0]       ram_wdata, ram_rdata;

  logic [CW:0]         ydiff, ymag;
  logic                yneg;
  logic [63:0]         b_w;
  logic [GW:0]         tx, ty;
  logic [RW-1:0]       adx, ady;
  logic [SW-1:0]       wv;
  logic [WW-1:0]       wtap;
  logic [RW:0]         rneg;
  logic [RW-1:0]       r_eff;
  logic [DW-1:0]       d_eff;
  logic [VSW:0]        dvs, trial;
  logic                cfg_wr;
  logic [HW-1:0]       e_nx;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= hvns_pkg::SEED_RST;
      stride_q <= hvns_pkg::STRIDE_RST;
      range_q  <= hvns_pkg::RANGE_RST;
      depth_q  <= hvns_pkg::DEPTH_RST;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        hvns_pkg::REG_SEED:   seed_q   <= pwdata;
        hvns_pkg::REG_STRIDE: stride_q <= pwdata[hvns_pkg::STRIDE_W-1:0];
        hvns_pkg::REG_RANGE:  range_q  <= pwdata[hvns_pkg::RANGE_W-1:0];
        hvns_pkg::REG_DEPTH:  depth_q  <= pwdata[hvns_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      hvns_pkg::REG_SEED:   prdata = seed_q;
      hvns_pkg::REG_STRIDE: prdata = hvns_pkg::CFG_DW'(stride_q);
      hvns_pkg::REG_RANGE:  prdata = hvns_pkg::CFG_DW'(range_q);
      hvns_pkg::REG_DEPTH:  prdata = hvns_pkg::CFG_DW'(depth_q);
      default:              prdata = '0;
    endcase
  end

  // clamp range and depth
  always_comb begin
    if (range_q == '0) begin
      r_eff = RW'(1);
    end else if (32'(range_q) > MAX_RANGE) begin
      r_eff = RW'(MAX_RANGE);
    end else begin
      r_eff = RW'(range_q);
    end
    if (32'(depth_q) > MAX_DEPTH) begin
      d_eff = DW'(MAX_DEPTH);
    end else begin
      d_eff = DW'(depth_q);
    end
  end

  // datapath helpers
  assign ydiff = {1'b0, y_q} - (CW + 1)'(h_q);
  assign yneg  = ydiff[CW];
  assign ymag  = yneg ? ((CW + 1)'(0) - ydiff) : ydiff;
  assign b_w   = m_q ^ hvns_pkg::HASH_K;
  assign tx    = {1'b0, cx_q} + (GW + 1)'(dx_q);
  assign ty    = {1'b0, cy_q} + (GW + 1)'(dy_q);
  assign adx   = dx_q[RW] ? RW'(-dx_q) : RW'(dx_q);
  assign ady   = dy_q[RW] ? RW'(-dy_q) : RW'(dy_q);
  assign wv    = SW'({r_q, 1'b0}) - SW'(1) - SW'(adx) - SW'(ady);
  assign wtap  = (!wv[SW-1] && (wv != '0)) ? wv[WW-1:0] : '0;
  assign rneg  = (RW + 1)'(0) - {1'b0, r_q};
  assign dvs   = (VSW + 1)'(wsum_q) << ds_q;
  assign trial = {1'b0, vsum_q} - dvs;
  assign e_nx  = e_q - HW'(r_q);

  // shared multiplier operand select
  always_comb begin
    ma = 32'(ram_rdata);
    mb = 32'(w1_q);
    case (state_q)
      S_HMUL: begin
        ma = 32'(r_q);
        mb = 32'(d_q);
      end
      S_RMUL: begin
        ma = 32'(ymag);
        mb = 32'(stride_q);
      end
      S_HASH: begin
        case (hs_q)
          4'd1: begin ma = n_q[31:0];  mb = hvns_pkg::HASH_K[31:0];  end
          4'd2: begin ma = n_q[31:0];  mb = hvns_pkg::HASH_K[63:32]; end
          4'd3: begin ma = n_q[63:32]; mb = hvns_pkg::HASH_K[31:0];  end
          4'd5: begin ma = m_q[31:0];  mb = b_w[31:0];  end
          4'd6: begin ma = m_q[31:0];  mb = b_w[63:32]; end
          4'd7: begin ma = m_q[63:32]; mb = b_w[31:0];  end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign prod_d = ma * mb;

  // sequencer
  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    y_d       = y_q;
    r_d       = r_q;
    d_d       = d_q;
    h_d       = h_q;
    e_d       = e_q;
    lvl_d     = lvl_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    hs_d      = hs_q;
    lin_d     = lin_q;
    lin_row_d = lin_row_q;
    n_d       = n_q;
    acc_d     = acc_q;
    m_d       = m_q;
    val1_d    = 1'b0;
    w1_d      = wtap;
    vsum_d    = vsum_q;
    wsum_d    = wsum_q;
    ds_d      = ds_q;
    q_d       = q_q;
    out_d     = out_q;
    oval_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = {lvl_q[0], cy_q, cx_q};
    ram_wdata = q_q;
    ram_raddr = {~lvl_q[0], ty[GW-1:0], tx[GW-1:0]};

    if (val2_q) begin
      vsum_d = vsum_q + prod_q[VSW-1:0];
      wsum_d = wsum_q + WSW'(w2_q);
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          x_d     = x_coord_i;
          y_d     = y_coord_i;
          r_d     = r_eff;
          d_d     = d_eff;
          state_d = S_HMUL;
        end
      end
      S_HMUL: state_d = S_HSET;
      S_HSET: begin
        h_d     = prod_q[HW-1:0];
        state_d = S_RMUL;
      end
      S_RMUL: state_d = S_RSET;
      S_RSET: begin
        lin_row_d = 64'(x_q) - 64'(h_q) + (yneg ? (64'd0 - prod_q) : prod_q);
        lin_d     = lin_row_d;
        cx_d      = CTR_G - GW'(h_q);
        cy_d      = CTR_G - GW'(h_q);
        hs_d      = 4'd0;
        state_d   = S_HASH;
      end
      S_HASH: begin
        hs_d = hs_q + 4'd1;
        case (hs_q)
          4'd0: n_d = seed_q + lin_q;
          4'd2: acc_d = prod_q;
          4'd3: acc_d[63:32] = acc_q[63:32] + prod_q[31:0];
          4'd4: m_d = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
          4'd6: acc_d = prod_q;
          4'd7: acc_d[63:32] = acc_q[63:32] + prod_q[31:0];
          4'd8: begin
            ram_we    = 1'b1;
            ram_waddr = {1'b0, cy_q, cx_q};
            ram_wdata = acc_q[39:32] + prod_q[7:0];
            hs_d      = 4'd0;
            if (cx_q == CTR_G + GW'(h_q)) begin
              if (cy_q == CTR_G + GW'(h_q)) begin
                if (d_q == '0) begin
                  state_d = S_FINRD;
                end else begin
                  lvl_d   = DW'(1);
                  e_d     = h_q - HW'(r_q);
                  cx_d    = CTR_G - GW'(h_q - HW'(r_q));
                  cy_d    = CTR_G - GW'(h_q - HW'(r_q));
                  dx_d    = rneg;
                  dy_d    = rneg;
                  vsum_d  = '0;
                  wsum_d  = '0;
                  state_d = S_TAP;
                end
              end else begin
                cx_d      = CTR_G - GW'(h_q);
                cy_d      = cy_q + GW'(1);
                lin_row_d = lin_row_q + 64'(stride_q);
                lin_d     = lin_row_q + 64'(stride_q);
              end
            end else begin
              cx_d  = cx_q + GW'(1);
              lin_d = lin_q + 64'd1;
            end
          end
          default: ;
        endcase
      end
      S_TAP: begin
        val1_d = 1'b1;
        if (dx_q == $signed({1'b0, r_q})) begin
          dx_d = rneg;
          if (dy_q == $signed({1'b0, r_q})) begin
            state_d = S_DRAIN;
          end else begin
            dy_d = dy_q + (RW + 1)'(1);
          end
        end else begin
          dx_d = dx_q + (RW + 1)'(1);
        end
      end
      S_DRAIN: begin
        if (!val1_q && !val2_q) begin
          ds_d    = 3'd7;
          q_d     = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!trial[VSW]) begin
          vsum_d    = trial[VSW-1:0];
          q_d[ds_q] = 1'b1;
        end
        ds_d = ds_q - 3'd1;
        if (ds_q == 3'd0) begin
          state_d = S_DWR;
        end
      end
      S_DWR: begin
        ram_we  = 1'b1;
        dx_d    = rneg;
        dy_d    = rneg;
        vsum_d  = '0;
        wsum_d  = '0;
        state_d = S_TAP;
        if (cx_q == CTR_G + GW'(e_q)) begin
          if (cy_q == CTR_G + GW'(e_q)) begin
            if (lvl_q == d_q) begin
              state_d = S_FINRD;
            end else begin
              lvl_d = lvl_q + DW'(1);
              e_d   = e_nx;
              cx_d  = CTR_G - GW'(e_nx);
              cy_d  = CTR_G - GW'(e_nx);
            end
          end else begin
            cx_d = CTR_G - GW'(e_q);
            cy_d = cy_q + GW'(1);
          end
        end else begin
          cx_d = cx_q + GW'(1);
        end
      end
      S_FINRD: begin
        ram_raddr = {d_q[0], CTR_G, CTR_G};
        state_d   = S_FINOUT;
      end
      S_FINOUT: begin
        out_d   = ram_rdata;
        oval_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      val1_q  <= 1'b0;
      val2_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      val1_q  <= val1_d;
      val2_q  <= val1_q;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    r_q       <= r_d;
    d_q       <= d_d;
    h_q       <= h_d;
    e_q       <= e_d;
    lvl_q     <= lvl_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    hs_q      <= hs_d;
    lin_q     <= lin_d;
    lin_row_q <= lin_row_d;
    n_q       <= n_d;
    acc_q     <= acc_d;
    m_q       <= m_d;
    prod_q    <= prod_d;
    w1_q      <= w1_d;
    w2_q      <= w1_q;
    vsum_q    <= vsum_d;
    wsum_q    <= wsum_d;
    ds_q      <= ds_d;
    q_q       <= q_d;
    out_q     <= out_d;
  end

  hvns_ram #(
    .WIDTH (VW),
    .DEPTH (RAM_D)
  ) u_plane (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy          = (state_q != S_IDLE);
  assign noise_valid_o = oval_q;
  assign noise_value_o = out_q;
endmodule
`default_nettype wire

[sv/hvns_checker.sv]
// Port-level checker for the hashed value-noise smoother, with its bind.
`default_nettype none
module hvns_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic noise_valid_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_valid_o |=> !noise_valid_o)
    else $error("result strobe held for two cycles");

  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> noise_valid_o)
    else $error("busy dropped without a result");
endmodule

bind hashed_value_noise_smoother hvns_checker u_hvns_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .noise_valid_o (noise_valid_o)
);
`default_nettype wire
